/* src/block_chain_allocator_top_assert.svh */
// ----------------------------------------------------------------------------
// Block chain allocator assertion macros
// Concurrent assertion wrappers used at the end of the top level.
// ----------------------------------------------------------------------------
`ifndef BLOCK_CHAIN_ALLOCATOR_TOP_ASSERT_SVH
`define BLOCK_CHAIN_ALLOCATOR_TOP_ASSERT_SVH

`ifndef ASSERT_OFF

// condition holds in the same cycle as its antecedent
`define BCA_ASSERT_SAME(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// condition holds in the cycle after its antecedent
`define BCA_ASSERT_NEXT(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`else

`define BCA_ASSERT_SAME(lbl, ante, cons, msg)
`define BCA_ASSERT_NEXT(lbl, ante, cons, msg)

`endif

`endif

/* src/bca_pkg.sv */
// ----------------------------------------------------------------------------
// Block chain allocator package
// Shared widths, codes, payload types and controller/datapath interface types.
// ----------------------------------------------------------------------------
`default_nettype none

package bca_pkg;

   localparam int MAP_BITS_DEF    = 16384;
   localparam int CHAIN_DEPTH_DEF = 16384;

   localparam int MODE_W = 3;
   localparam int BLOCK_W = 14;
   localparam int HOPS_W = 14;
   localparam int LINK_W = 32;
   localparam int STAT_W = 3;
   localparam int DB_W = 14;
   localparam int SL_W = 15;
   localparam int CSR_IDX_W = 2;
   localparam int CSR_DATA_W = 32;

   localparam logic [LINK_W-1:0] END_MARK = 32'hFFFF_FFFF;
   localparam logic [SL_W-1:0] SCAN_LIMIT_RST = 15'd16384;

   // operation codes
   localparam logic [MODE_W-1:0] MODE_SEEK   = 3'd0;
   localparam logic [MODE_W-1:0] MODE_ALLOC  = 3'd1;
   localparam logic [MODE_W-1:0] MODE_APPEND = 3'd2;
   localparam logic [MODE_W-1:0] MODE_TRIM   = 3'd3;
   localparam logic [MODE_W-1:0] MODE_SET    = 3'd4;
   localparam logic [MODE_W-1:0] MODE_CLEAR  = 3'd5;
   localparam logic [MODE_W-1:0] MODE_WLINK  = 3'd6;
   localparam logic [MODE_W-1:0] MODE_READ   = 3'd7;

   // result status codes
   localparam logic [STAT_W-1:0] STAT_OK      = 3'd0;
   localparam logic [STAT_W-1:0] STAT_END     = 3'd1;
   localparam logic [STAT_W-1:0] STAT_NOSPACE = 3'd2;
   localparam logic [STAT_W-1:0] STAT_SINGLE  = 3'd3;
   localparam logic [STAT_W-1:0] STAT_RANGE   = 3'd4;

   // configuration register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_DATA_BASE  = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_SCAN_LIMIT = 2'd1;

   typedef struct packed {
      logic [MODE_W-1:0]  mode;
      logic [BLOCK_W-1:0] block;
      logic [HOPS_W-1:0]  hops;
      logic [LINK_W-1:0]  link_value;
   } req_type;

   typedef struct packed {
      logic [LINK_W-1:0] result_block;
      logic              bit_value;
      logic [STAT_W-1:0] status;
   } rsp_type;

   typedef enum logic [3:0] {
      CS_CLEAR,
      CS_IDLE,
      CS_DISPATCH,
      CS_LINK_RD,
      CS_LINK_CHK,
      CS_SCAN_RD,
      CS_SCAN_CHK,
      CS_MAP_RD,
      CS_MAP_WR,
      CS_LINK_END,
      CS_READ_CAP,
      CS_RESP
   } ctrl_state_type;

   typedef enum logic [2:0] {
      RES_ZERO,
      RES_CUR,
      RES_IDX,
      RES_BLK,
      RES_LINK
   } res_sel_type;

   typedef enum logic [1:0] {
      LA_CUR,
      LA_IDX,
      LA_PRED
   } link_addr_sel_type;

   typedef enum logic [1:0] {
      LD_END,
      LD_IDX,
      LD_VALUE
   } link_data_sel_type;

   typedef struct packed {
      logic              load;
      logic              clr_wr;
      logic              advance;
      logic              map_rd_scan;
      logic              map_wr;
      logic              map_set;
      logic              scan_next;
      logic              take_free;
      logic              pos_tail;
      logic              link_wr;
      link_addr_sel_type link_asel;
      link_data_sel_type link_dsel;
      logic              fin;
      res_sel_type       fin_res;
      logic              fin_bit;
      logic [STAT_W-1:0] fin_st;
      logic              out_load;
   } dp_cmd_type;

   typedef struct packed {
      logic [MODE_W-1:0] mode;
      logic              blk_ok;
      logic              pos_ok;
      logic              hops_done;
      logic              nxt_end;
      logic              nxt_bad;
      logic              walk_lim;
      logic              has_pred;
      logic              trim_oob;
      logic              scan_over;
      logic              found;
      logic              found_bad;
      logic              clr_last;
   } dp_stat_type;

endpackage

`default_nettype wire

/* src/block_chain_allocator_top.sv */
// ----------------------------------------------------------------------------
// Block chain allocator
// Used-block bitmap with a next-block link table: chain seek, allocate,
// append, trim and direct bitmap/link access, one request at a time.
// ----------------------------------------------------------------------------
//
// Channel  Dir  Handshake              Payload
// req      in   req_valid / req_ready  req_data  (bca_pkg::req_type)
// rsp      out  rsp_valid / rsp_ready  rsp_data  (bca_pkg::rsp_type)
// csr      in   csr_valid / csr_ready  csr_index, csr_wdata (csr_ready is tied high)
//
// After reset the bitmap is cleared one byte a cycle, (MAP_BITS+7)/8 bytes
// (2048 by default); no request is taken meanwhile, csr writes still are.
// Per request the steps are: capture and decode, a link read and check per link
// followed in a seek or tail walk, a read and check per bitmap byte searched for a
// free bit, a bitmap read-modify-write, any extra link write, then the result load.
// The link memory's single read port sets the walk rate, the bitmap port the
// scan rate; a held result stalls only the finishing request.
// ----------------------------------------------------------------------------
`default_nettype none

`include "block_chain_allocator_top_assert.svh"

module block_chain_allocator_top #(
   parameter int MAP_BITS    = bca_pkg::MAP_BITS_DEF,
   parameter int CHAIN_DEPTH = bca_pkg::CHAIN_DEPTH_DEF
) (
   input  wire logic                           clock,
   input  wire logic                           reset,
   input  wire logic                           req_valid,
   output logic                                req_ready,
   input  wire bca_pkg::req_type               req_data,
   output logic                                rsp_valid,
   input  wire logic                           rsp_ready,
   output bca_pkg::rsp_type                    rsp_data,
   input  wire logic                           csr_valid,
   output logic                                csr_ready,
   input  wire logic [bca_pkg::CSR_IDX_W-1:0]  csr_index,
   input  wire logic [bca_pkg::CSR_DATA_W-1:0] csr_wdata
);

   bca_pkg::dp_cmd_type  dp_cmd;
   bca_pkg::dp_stat_type dp_stat;

   assign csr_ready = 1'b1;

   bca_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .stat      (dp_stat),
      .cmd       (dp_cmd)
   );

   bca_dp #(
      .MAP_BITS    (MAP_BITS),
      .CHAIN_DEPTH (CHAIN_DEPTH)
   ) u_dp (
      .clock     (clock),
      .reset     (reset),
      .req_data  (req_data),
      .csr_valid (csr_valid),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .cmd       (dp_cmd),
      .stat      (dp_stat),
      .rsp_data  (rsp_data)
   );

   // one request in flight: a transfer closes the request port until the result is loaded
   `BCA_ASSERT_NEXT(a_single_item, req_valid && req_ready, !req_ready, "request taken while busy")

   // the clearing pass never overlaps an accepted request
   `BCA_ASSERT_SAME(a_clear_idle, dp_cmd.clr_wr, !req_ready && !dp_cmd.load, "request during clear")

   // a loaded result is presented on the next cycle
   `BCA_ASSERT_NEXT(a_rsp_shown, dp_cmd.out_load, rsp_valid, "loaded result not presented")

   // only one bitmap write source at a time
   `BCA_ASSERT_SAME(a_map_wr_excl, dp_cmd.map_wr, !dp_cmd.clr_wr, "bitmap write clash")

endmodule

`default_nettype wire

/* src/bca_ram.sv */
// ----------------------------------------------------------------------------
// Generic single-port-write RAM
// One write port, one read port with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module bca_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 2048,
   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  wire logic             clock,
   input  wire logic             wr_en,
   input  wire logic [AW-1:0]    wr_addr,
   input  wire logic [WIDTH-1:0] wr_data,
   input  wire logic [AW-1:0]    rd_addr,
   output logic      [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

/* src/bca_ctrl.sv */
// ----------------------------------------------------------------------------
// Block chain allocator controller
// Sequences clearing, chain walks, bitmap scans and table updates.
// ----------------------------------------------------------------------------
`default_nettype none

module bca_ctrl (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 req_valid,
   output logic                      req_ready,
   output logic                      rsp_valid,
   input  wire logic                 rsp_ready,
   input  wire bca_pkg::dp_stat_type stat,
   output bca_pkg::dp_cmd_type       cmd
);

   bca_pkg::ctrl_state_type state_ff, state_in;
   logic out_valid_ff, out_valid_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= bca_pkg::CS_CLEAR;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      req_ready = (state_ff == bca_pkg::CS_IDLE);

      case (state_ff)
         bca_pkg::CS_CLEAR: begin
            cmd.clr_wr = 1'b1;
            if (stat.clr_last) begin
               state_in = bca_pkg::CS_IDLE;
            end
         end

         bca_pkg::CS_IDLE: begin
            if (req_valid) begin
               cmd.load = 1'b1;
               state_in = bca_pkg::CS_DISPATCH;
            end
         end

         bca_pkg::CS_DISPATCH: begin
            case (stat.mode)
               bca_pkg::MODE_SEEK,
               bca_pkg::MODE_APPEND,
               bca_pkg::MODE_TRIM: begin
                  if (stat.blk_ok) begin
                     state_in = bca_pkg::CS_LINK_RD;
                  end else begin
                     cmd.fin    = 1'b1;
                     cmd.fin_st = bca_pkg::STAT_RANGE;
                     state_in   = bca_pkg::CS_RESP;
                  end
               end
               bca_pkg::MODE_ALLOC: begin
                  state_in = bca_pkg::CS_SCAN_RD;
               end
               bca_pkg::MODE_SET,
               bca_pkg::MODE_CLEAR: begin
                  if (stat.pos_ok) begin
                     state_in = bca_pkg::CS_MAP_RD;
                  end else begin
                     cmd.fin    = 1'b1;
                     cmd.fin_st = bca_pkg::STAT_RANGE;
                     state_in   = bca_pkg::CS_RESP;
                  end
               end
               bca_pkg::MODE_WLINK: begin
                  cmd.fin  = 1'b1;
                  state_in = bca_pkg::CS_RESP;
                  if (stat.blk_ok) begin
                     cmd.link_wr   = 1'b1;
                     cmd.link_asel = bca_pkg::LA_CUR;
                     cmd.link_dsel = bca_pkg::LD_VALUE;
                     cmd.fin_res   = bca_pkg::RES_BLK;
                     cmd.fin_st    = bca_pkg::STAT_OK;
                  end else begin
                     cmd.fin_st = bca_pkg::STAT_RANGE;
                  end
               end
               default: begin
                  // read entry: both memories see the block address now
                  state_in = bca_pkg::CS_READ_CAP;
               end
            endcase
         end

         bca_pkg::CS_LINK_RD: begin
            if (stat.mode == bca_pkg::MODE_SEEK && stat.hops_done) begin
               cmd.fin     = 1'b1;
               cmd.fin_res = bca_pkg::RES_CUR;
               cmd.fin_st  = bca_pkg::STAT_OK;
               state_in    = bca_pkg::CS_RESP;
            end else begin
               state_in = bca_pkg::CS_LINK_CHK;
            end
         end

         bca_pkg::CS_LINK_CHK: begin
            if (stat.nxt_end) begin
               case (stat.mode)
                  bca_pkg::MODE_SEEK: begin
                     cmd.fin     = 1'b1;
                     cmd.fin_res = bca_pkg::RES_CUR;
                     cmd.fin_st  = bca_pkg::STAT_END;
                     state_in    = bca_pkg::CS_RESP;
                  end
                  bca_pkg::MODE_APPEND: begin
                     state_in = bca_pkg::CS_SCAN_RD;
                  end
                  default: begin
                     if (!stat.has_pred) begin
                        cmd.fin     = 1'b1;
                        cmd.fin_res = bca_pkg::RES_BLK;
                        cmd.fin_st  = bca_pkg::STAT_SINGLE;
                        state_in    = bca_pkg::CS_RESP;
                     end else if (stat.trim_oob) begin
                        cmd.fin    = 1'b1;
                        cmd.fin_st = bca_pkg::STAT_RANGE;
                        state_in   = bca_pkg::CS_RESP;
                     end else begin
                        cmd.pos_tail = 1'b1;
                        state_in     = bca_pkg::CS_MAP_RD;
                     end
                  end
               endcase
            end else if (stat.nxt_bad ||
                         (stat.mode != bca_pkg::MODE_SEEK && stat.walk_lim)) begin
               // seek keeps the last good block, the walks report zero
               cmd.fin     = 1'b1;
               cmd.fin_res = (stat.mode == bca_pkg::MODE_SEEK) ? bca_pkg::RES_CUR
                                                                : bca_pkg::RES_ZERO;
               cmd.fin_st  = bca_pkg::STAT_RANGE;
               state_in    = bca_pkg::CS_RESP;
            end else begin
               cmd.advance = 1'b1;
               state_in    = bca_pkg::CS_LINK_RD;
            end
         end

         bca_pkg::CS_SCAN_RD: begin
            cmd.map_rd_scan = 1'b1;
            if (stat.scan_over) begin
               cmd.fin    = 1'b1;
               cmd.fin_st = bca_pkg::STAT_NOSPACE;
               state_in   = bca_pkg::CS_RESP;
            end else begin
               state_in = bca_pkg::CS_SCAN_CHK;
            end
         end

         bca_pkg::CS_SCAN_CHK: begin
            if (stat.found) begin
               if (stat.found_bad) begin
                  cmd.fin    = 1'b1;
                  cmd.fin_st = bca_pkg::STAT_RANGE;
                  state_in   = bca_pkg::CS_RESP;
               end else begin
                  cmd.take_free = 1'b1;
                  state_in      = bca_pkg::CS_MAP_RD;
               end
            end else begin
               cmd.scan_next = 1'b1;
               state_in      = bca_pkg::CS_SCAN_RD;
            end
         end

         bca_pkg::CS_MAP_RD: begin
            state_in = bca_pkg::CS_MAP_WR;
         end

         bca_pkg::CS_MAP_WR: begin
            cmd.map_wr  = 1'b1;
            cmd.map_set = stat.mode inside {bca_pkg::MODE_ALLOC, bca_pkg::MODE_APPEND,
                                            bca_pkg::MODE_SET};
            cmd.fin_st  = bca_pkg::STAT_OK;
            state_in    = bca_pkg::CS_RESP;
            case (stat.mode)
               bca_pkg::MODE_ALLOC: begin
                  cmd.link_wr   = 1'b1;
                  cmd.link_asel = bca_pkg::LA_IDX;
                  cmd.link_dsel = bca_pkg::LD_END;
                  cmd.fin       = 1'b1;
                  cmd.fin_res   = bca_pkg::RES_IDX;
               end
               bca_pkg::MODE_APPEND: begin
                  // tail gets the new block first, end mark follows
                  cmd.link_wr   = 1'b1;
                  cmd.link_asel = bca_pkg::LA_CUR;
                  cmd.link_dsel = bca_pkg::LD_IDX;
                  state_in      = bca_pkg::CS_LINK_END;
               end
               bca_pkg::MODE_TRIM: begin
                  cmd.link_wr   = 1'b1;
                  cmd.link_asel = bca_pkg::LA_PRED;
                  cmd.link_dsel = bca_pkg::LD_END;
                  cmd.fin       = 1'b1;
                  cmd.fin_res   = bca_pkg::RES_CUR;
               end
               default: begin
                  cmd.fin     = 1'b1;
                  cmd.fin_res = bca_pkg::RES_BLK;
               end
            endcase
         end

         bca_pkg::CS_LINK_END: begin
            cmd.link_wr   = 1'b1;
            cmd.link_asel = bca_pkg::LA_IDX;
            cmd.link_dsel = bca_pkg::LD_END;
            cmd.fin       = 1'b1;
            cmd.fin_res   = bca_pkg::RES_IDX;
            cmd.fin_st    = bca_pkg::STAT_OK;
            state_in      = bca_pkg::CS_RESP;
         end

         bca_pkg::CS_READ_CAP: begin
            cmd.fin     = 1'b1;
            cmd.fin_res = stat.blk_ok ? bca_pkg::RES_LINK : bca_pkg::RES_ZERO;
            cmd.fin_bit = stat.pos_ok;
            cmd.fin_st  = (stat.blk_ok && stat.pos_ok) ? bca_pkg::STAT_OK
                                                       : bca_pkg::STAT_RANGE;
            state_in    = bca_pkg::CS_RESP;
         end

         bca_pkg::CS_RESP: begin
            if (!out_valid_ff || rsp_ready) begin
               cmd.out_load = 1'b1;
               state_in     = bca_pkg::CS_IDLE;
            end
         end

         default: begin
            state_in = bca_pkg::CS_IDLE;
         end
      endcase

      if (cmd.out_load) begin
         out_valid_in = 1'b1;
      end else if (rsp_ready) begin
         out_valid_in = 1'b0;
      end else begin
         out_valid_in = out_valid_ff;
      end
   end

   assign rsp_valid = out_valid_ff;

endmodule

`default_nettype wire

/* src/bca_dp.sv */
// ----------------------------------------------------------------------------
// Block chain allocator datapath
// Bitmap and link memories, walk and scan registers, result registers.
// ----------------------------------------------------------------------------
`default_nettype none

module bca_dp #(
   parameter int MAP_BITS    = bca_pkg::MAP_BITS_DEF,
   parameter int CHAIN_DEPTH = bca_pkg::CHAIN_DEPTH_DEF
) (
   input  wire logic                              clock,
   input  wire logic                              reset,
   input  wire bca_pkg::req_type                  req_data,
   input  wire logic                              csr_valid,
   input  wire logic [bca_pkg::CSR_IDX_W-1:0]     csr_index,
   input  wire logic [bca_pkg::CSR_DATA_W-1:0]    csr_wdata,
   input  wire bca_pkg::dp_cmd_type               cmd,
   output bca_pkg::dp_stat_type                   stat,
   output bca_pkg::rsp_type                       rsp_data
);

   localparam int LIW       = $clog2(CHAIN_DEPTH);
   localparam int MAP_BYTES = (MAP_BITS + 7) / 8;
   localparam int BAW       = $clog2(MAP_BYTES);
   localparam int POS_W     = BAW + 3;
   localparam int CW        = ($clog2(CHAIN_DEPTH + 1) > bca_pkg::HOPS_W) ?
                              $clog2(CHAIN_DEPTH + 1) : bca_pkg::HOPS_W;

   // captured request
   logic [bca_pkg::MODE_W-1:0]  mode_ff, mode_in;
   logic [bca_pkg::BLOCK_W-1:0] blk_ff, blk_in;
   logic [bca_pkg::HOPS_W-1:0]  hops_ff, hops_in;
   logic [bca_pkg::LINK_W-1:0]  lv_ff, lv_in;

   // walk and scan state
   logic [LIW-1:0]   cur_ff, cur_in;
   logic [LIW-1:0]   pred_ff, pred_in;
   logic [LIW-1:0]   idx_ff, idx_in;
   logic             has_pred_ff, has_pred_in;
   logic [CW-1:0]    cnt_ff, cnt_in;
   logic [POS_W-1:0] pos_ff, pos_in;
   logic [BAW:0]     byte_ff, byte_in;
   logic [BAW-1:0]   clr_ff, clr_in;

   // working and output result
   logic [bca_pkg::LINK_W-1:0] res_ff, res_in;
   logic                       bitv_ff, bitv_in;
   logic [bca_pkg::STAT_W-1:0] st_ff, st_in;
   bca_pkg::rsp_type           out_ff, out_in;

   // configuration
   logic [bca_pkg::DB_W-1:0] db_ff, db_in;
   logic [bca_pkg::SL_W-1:0] sl_ff, sl_in;

   // memory ports
   logic                       map_we;
   logic [BAW-1:0]             map_waddr;
   logic [7:0]                 map_wdata;
   logic [BAW-1:0]             map_raddr;
   logic [7:0]                 map_rdata;
   logic                       link_we;
   logic [LIW-1:0]             link_waddr;
   logic [bca_pkg::LINK_W-1:0] link_wdata;
   logic [bca_pkg::LINK_W-1:0] link_rdata;

   logic [31:0] lim;
   logic [31:0] db_wide;
   logic [31:0] found_pos;
   logic [31:0] tail_pos;
   logic [7:0]  cand;
   logic [2:0]  bit_sel;
   logic [7:0]  bit_mask;

   bca_ram #(
      .WIDTH (8),
      .DEPTH (MAP_BYTES)
   ) u_map_ram (
      .clock   (clock),
      .wr_en   (map_we),
      .wr_addr (map_waddr),
      .wr_data (map_wdata),
      .rd_addr (map_raddr),
      .rd_data (map_rdata)
   );

   bca_ram #(
      .WIDTH (bca_pkg::LINK_W),
      .DEPTH (CHAIN_DEPTH)
   ) u_link_ram (
      .clock   (clock),
      .wr_en   (link_we),
      .wr_addr (link_waddr),
      .wr_data (link_wdata),
      .rd_addr (cur_ff),
      .rd_data (link_rdata)
   );

   always_comb begin
      db_wide  = 32'(db_ff);
      lim      = (32'(sl_ff) < 32'(MAP_BITS)) ? 32'(sl_ff) : 32'(MAP_BITS);
      tail_pos = 32'(cur_ff) + db_wide;

      // first clear bit of the scanned byte below the limit, MSB first
      found_pos = 32'({byte_ff, 3'd0});
      for (int j = 7; j >= 0; j--) begin
         cand[j] = !map_rdata[3'(7 - j)] && (32'({byte_ff, 3'(j)}) < lim);
         if (cand[j]) begin
            found_pos = 32'({byte_ff, 3'(j)});
         end
      end

      bit_sel  = 3'd7 - pos_ff[2:0];
      bit_mask = 8'h01 << bit_sel;

      stat.mode      = mode_ff;
      stat.blk_ok    = 32'(blk_ff) < 32'(CHAIN_DEPTH);
      stat.pos_ok    = 32'(blk_ff) < 32'(MAP_BITS);
      stat.hops_done = 32'(cnt_ff) == 32'(hops_ff);
      stat.nxt_end   = link_rdata == bca_pkg::END_MARK;
      stat.nxt_bad   = link_rdata >= 32'(CHAIN_DEPTH);
      stat.walk_lim  = 32'(cnt_ff) >= 32'(CHAIN_DEPTH);
      stat.has_pred  = has_pred_ff;
      stat.trim_oob  = tail_pos >= 32'(MAP_BITS);
      stat.scan_over = 32'({byte_ff, 3'd0}) >= lim;
      stat.found     = |cand;
      stat.found_bad = (found_pos < db_wide) ||
                       ((found_pos - db_wide) >= 32'(CHAIN_DEPTH));
      stat.clr_last  = clr_ff == BAW'(MAP_BYTES - 1);

      // bitmap port
      map_we    = cmd.clr_wr | cmd.map_wr;
      map_waddr = cmd.clr_wr ? clr_ff : pos_ff[POS_W-1:3];
      if (cmd.clr_wr) begin
         map_wdata = 8'h00;
      end else if (cmd.map_set) begin
         map_wdata = map_rdata | bit_mask;
      end else begin
         map_wdata = map_rdata & ~bit_mask;
      end
      map_raddr = cmd.map_rd_scan ? byte_ff[BAW-1:0] : pos_ff[POS_W-1:3];

      // link port
      link_we = cmd.link_wr;
      case (cmd.link_asel)
         bca_pkg::LA_IDX:  link_waddr = idx_ff;
         bca_pkg::LA_PRED: link_waddr = pred_ff;
         default:          link_waddr = cur_ff;
      endcase
      case (cmd.link_dsel)
         bca_pkg::LD_IDX:   link_wdata = 32'(idx_ff);
         bca_pkg::LD_VALUE: link_wdata = lv_ff;
         default:           link_wdata = bca_pkg::END_MARK;
      endcase
   end

   always_comb begin
      mode_in     = mode_ff;
      blk_in      = blk_ff;
      hops_in     = hops_ff;
      lv_in       = lv_ff;
      cur_in      = cur_ff;
      pred_in     = pred_ff;
      idx_in      = idx_ff;
      has_pred_in = has_pred_ff;
      cnt_in      = cnt_ff;
      pos_in      = pos_ff;
      byte_in     = byte_ff;
      clr_in      = clr_ff;
      res_in      = res_ff;
      bitv_in     = bitv_ff;
      st_in       = st_ff;
      out_in      = out_ff;
      db_in       = db_ff;
      sl_in       = sl_ff;

      if (cmd.load) begin
         mode_in     = req_data.mode;
         blk_in      = req_data.block;
         hops_in     = req_data.hops;
         lv_in       = req_data.link_value;
         cur_in      = LIW'(req_data.block);
         pos_in      = POS_W'(req_data.block);
         has_pred_in = 1'b0;
         cnt_in      = '0;
         byte_in     = '0;
      end

      if (cmd.advance) begin
         pred_in     = cur_ff;
         has_pred_in = 1'b1;
         cur_in      = LIW'(link_rdata);
         cnt_in      = cnt_ff + 1'b1;
      end

      if (cmd.scan_next) begin
         byte_in = byte_ff + 1'b1;
      end

      if (cmd.take_free) begin
         pos_in = POS_W'(found_pos);
         idx_in = LIW'(found_pos - db_wide);
      end

      if (cmd.pos_tail) begin
         pos_in = POS_W'(tail_pos);
      end

      if (cmd.clr_wr) begin
         clr_in = clr_ff + 1'b1;
      end

      if (cmd.fin) begin
         case (cmd.fin_res)
            bca_pkg::RES_CUR:  res_in = 32'(cur_ff);
            bca_pkg::RES_IDX:  res_in = 32'(idx_ff);
            bca_pkg::RES_BLK:  res_in = 32'(blk_ff);
            bca_pkg::RES_LINK: res_in = link_rdata;
            default:           res_in = '0;
         endcase
         bitv_in = cmd.fin_bit & map_rdata[bit_sel];
         st_in   = cmd.fin_st;
      end

      if (cmd.out_load) begin
         out_in.result_block = res_ff;
         out_in.bit_value    = bitv_ff;
         out_in.status       = st_ff;
      end

      if (csr_valid) begin
         case (csr_index)
            bca_pkg::CSR_DATA_BASE:  db_in = csr_wdata[bca_pkg::DB_W-1:0];
            bca_pkg::CSR_SCAN_LIMIT: sl_in = csr_wdata[bca_pkg::SL_W-1:0];
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         clr_ff <= '0;
         db_ff  <= '0;
         sl_ff  <= bca_pkg::SCAN_LIMIT_RST;
      end else begin
         clr_ff <= clr_in;
         db_ff  <= db_in;
         sl_ff  <= sl_in;
      end
   end

   always_ff @(posedge clock) begin
      mode_ff     <= mode_in;
      blk_ff      <= blk_in;
      hops_ff     <= hops_in;
      lv_ff       <= lv_in;
      cur_ff      <= cur_in;
      pred_ff     <= pred_in;
      idx_ff      <= idx_in;
      has_pred_ff <= has_pred_in;
      cnt_ff      <= cnt_in;
      pos_ff      <= pos_in;
      byte_ff     <= byte_in;
      res_ff      <= res_in;
      bitv_ff     <= bitv_in;
      st_ff       <= st_in;
      out_ff      <= out_in;
   end

   assign rsp_data = out_ff;

endmodule

`default_nettype wire

/* test/tb_block_chain_allocator_top.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Block chain allocator testbench
// Runs a short directed table and then random chain traffic: allocate, append,
// seek, trim and direct bitmap/link access. The register settings change from
// phase to phase. Results are checked against a behavioural copy of the bitmap
// and link table kept inside the bench, or against a directed row's own result.
// ----------------------------------------------------------------------------
module tb_block_chain_allocator_top;
   import bca_pkg::*;

   localparam int MAP_BITS       = MAP_BITS_DEF;
   localparam int CHAIN_DEPTH    = CHAIN_DEPTH_DEF;
   localparam int WALK_CAP       = 48;      // longest walk the random part may cause
   localparam int WATCHDOG_LIMIT = 100000;
   localparam int TAIL_CYCLES    = 40;
   localparam logic [CSR_IDX_W-1:0] CSR_SPARE = 2'd3;

   typedef struct packed {
      req_type stim;
      logic    typed;
      rsp_type want;
   } dir_row_type;

   logic                  clock;
   logic                  reset;
   logic                  req_valid;
   logic                  req_ready;
   req_type               req_data;
   logic                  rsp_valid;
   logic                  rsp_ready;
   rsp_type               rsp_data;
   logic                  csr_valid;
   logic                  csr_ready;
   logic [CSR_IDX_W-1:0]  csr_index;
   logic [CSR_DATA_W-1:0] csr_wdata;

   // shadow of the block's state
   bit          map_used  [MAP_BITS];
   logic [31:0] link_word [CHAIN_DEPTH];
   bit          link_set  [CHAIN_DEPTH];
   int          cfg_base;
   int          cfg_limit;

   rsp_type     pending_rsp[$];
   int          chain_head[$];
   dir_row_type dir_rows[$];

   int mismatches    = 0;
   int requests_sent = 0;
   int settings_run  = 0;
   int status_seen[8];
   int req_idle_pct  = 0;
   int rsp_stall_pct = 0;
   int hold_left     = 0;
   int stall_cycles;

   block_chain_allocator_top dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   initial clock = 1'b0;
   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   // first clear bit below the scan limit, MSB-first order is invisible here
   function automatic logic [STAT_W-1:0] find_free_bit(output int pos);
      int lim;
      int p;
      lim = (cfg_limit < MAP_BITS) ? cfg_limit : MAP_BITS;
      p = 0;
      while (p < lim && map_used[p]) p++;
      pos = p;
      if (p >= lim) return STAT_NOSPACE;
      if (p < cfg_base || p - cfg_base >= CHAIN_DEPTH) return STAT_RANGE;
      return STAT_OK;
   endfunction

   function automatic logic [STAT_W-1:0] walk_to_tail(input int start, output int tail,
                                                      output int pred, output bit has_pred);
      int cur;
      int n;
      logic [31:0] nxt;
      cur = start;
      tail = 0;
      pred = 0;
      has_pred = 1'b0;
      for (n = 0; n <= CHAIN_DEPTH; n++) begin
         nxt = link_word[cur];
         if (nxt == END_MARK) begin
            tail = cur;
            return STAT_OK;
         end
         if (nxt >= CHAIN_DEPTH || n >= CHAIN_DEPTH) return STAT_RANGE;
         pred = cur;
         has_pred = 1'b1;
         cur = nxt;
      end
      return STAT_RANGE;
   endfunction

   // applies one request to the shadow state and gives the result it must produce
   task automatic predict_result(input req_type r, output rsp_type e);
      int blk, pos, idx, tail, pred, i;
      bit has_pred;
      logic [31:0] nxt;
      e = '0;
      blk = r.block;
      case (r.mode)
         MODE_SEEK: begin
            if (blk >= CHAIN_DEPTH) e.status = STAT_RANGE;
            else begin
               e.result_block = blk;
               for (i = 0; i < r.hops; i++) begin
                  nxt = link_word[e.result_block];
                  if (nxt == END_MARK) begin
                     e.status = STAT_END;
                     break;
                  end
                  if (nxt >= CHAIN_DEPTH) begin
                     e.status = STAT_RANGE;
                     break;
                  end
                  e.result_block = nxt;
               end
            end
         end
         MODE_ALLOC: begin
            e.status = find_free_bit(pos);
            if (e.status == STAT_OK) begin
               idx = pos - cfg_base;
               map_used[pos] = 1'b1;
               link_word[idx] = END_MARK;
               link_set[idx] = 1'b1;
               e.result_block = idx;
            end
         end
         MODE_APPEND: begin
            if (blk >= CHAIN_DEPTH) e.status = STAT_RANGE;
            else begin
               e.status = walk_to_tail(blk, tail, pred, has_pred);
               if (e.status == STAT_OK) e.status = find_free_bit(pos);
               if (e.status == STAT_OK) begin
                  idx = pos - cfg_base;
                  map_used[pos] = 1'b1;
                  link_word[tail] = idx;
                  link_word[idx] = END_MARK;
                  link_set[idx] = 1'b1;
                  e.result_block = idx;
               end
            end
         end
         MODE_TRIM: begin
            if (blk >= CHAIN_DEPTH) e.status = STAT_RANGE;
            else begin
               e.status = walk_to_tail(blk, tail, pred, has_pred);
               if (e.status == STAT_OK) begin
                  if (!has_pred) begin
                     e.status = STAT_SINGLE;
                     e.result_block = blk;
                  end else if (tail + cfg_base >= MAP_BITS) begin
                     e.status = STAT_RANGE;
                  end else begin
                     map_used[tail + cfg_base] = 1'b0;
                     link_word[pred] = END_MARK;
                     e.result_block = tail;
                  end
               end
            end
         end
         MODE_SET, MODE_CLEAR: begin
            if (blk >= MAP_BITS) e.status = STAT_RANGE;
            else begin
               map_used[blk] = (r.mode == MODE_SET);
               e.result_block = blk;
            end
         end
         MODE_WLINK: begin
            if (blk >= CHAIN_DEPTH) e.status = STAT_RANGE;
            else begin
               link_word[blk] = r.link_value;
               link_set[blk] = 1'b1;
               e.result_block = blk;
            end
         end
         default: begin
            if (blk < CHAIN_DEPTH) e.result_block = link_word[blk];
            else e.status = STAT_RANGE;
            if (blk < MAP_BITS) e.bit_value = map_used[blk];
            else e.status = STAT_RANGE;
         end
      endcase
   endtask

   // number of link reads a request will cause, -1 if it would touch an unwritten
   // entry or run longer than the random part allows
   function automatic int link_reads(input req_type r);
      int cur, n, lim;
      logic [31:0] nxt;
      if (r.mode == MODE_READ) return link_set[r.block] ? 1 : -1;
      if (r.mode != MODE_SEEK && r.mode != MODE_APPEND && r.mode != MODE_TRIM) return 0;
      cur = r.block;
      lim = (r.mode == MODE_SEEK) ? int'(r.hops) : WALK_CAP + 1;
      for (n = 0; n < lim; n++) begin
         if (n >= WALK_CAP || !link_set[cur]) return -1;
         nxt = link_word[cur];
         if (nxt == END_MARK || nxt >= CHAIN_DEPTH) return n + 1;
         cur = nxt;
      end
      return n;
   endfunction

   function automatic int any_head();
      if (chain_head.size() == 0) return $urandom_range(0, CHAIN_DEPTH - 1);
      return chain_head[$urandom_range(0, chain_head.size() - 1)];
   endfunction

   // mostly chain traffic on known heads, the rest bitmap and link noise
   function automatic req_type next_random_item();
      req_type r;
      int sel, attempt;
      for (attempt = 0; attempt < 8; attempt++) begin
         sel = $urandom_range(0, 99);
         r.block = $urandom_range(0, CHAIN_DEPTH - 1);
         r.hops = $urandom_range(0, CHAIN_DEPTH - 1);
         r.link_value = $urandom();
         if (sel < 18) begin
            r.mode = MODE_ALLOC;
         end else if (sel < 40) begin
            r.mode = MODE_APPEND;
            r.block = any_head();
         end else if (sel < 57) begin
            r.mode = MODE_SEEK;
            r.block = any_head();
            if ($urandom_range(0, 7) != 0) r.hops = $urandom_range(0, 8);
         end else if (sel < 70) begin
            r.mode = MODE_TRIM;
            r.block = any_head();
         end else if (sel < 79) begin
            r.mode = MODE_READ;
            if ($urandom_range(0, 3) != 0) r.block = any_head();
         end else if (sel < 86) begin
            r.mode = MODE_SET;
            if ($urandom_range(0, 3) != 0) r.block = $urandom_range(0, 255);
         end else if (sel < 92) begin
            r.mode = MODE_CLEAR;
            if ($urandom_range(0, 3) != 0) r.block = $urandom_range(0, 255);
         end else begin
            r.mode = MODE_WLINK;
            if ($urandom_range(0, 1) != 0) r.block = any_head();
            case ($urandom_range(0, 3))
               0: r.link_value = END_MARK;
               1: r.link_value = any_head();
               2: r.link_value = $urandom_range(CHAIN_DEPTH, 32'hFFFF_FFFE);
               default: ;
            endcase
         end
         if (link_reads(r) >= 0) return r;
      end
      r.mode = MODE_ALLOC;
      return r;
   endfunction

   task automatic send_item(input req_type r, input bit typed, input rsp_type want);
      rsp_type e;
      int gap;
      gap = 0;
      while (gap < 200 && $urandom_range(0, 99) < req_idle_pct) gap++;
      @(negedge clock);
      if (gap > 0) begin
         req_valid = 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_valid = 1'b1;
      req_data = r;
      do @(posedge clock); while (!req_ready);
      predict_result(r, e);
      if (typed) e = want;
      pending_rsp.push_back(e);
      requests_sent++;
      status_seen[e.status]++;
      if (r.mode == MODE_ALLOC && e.status == STAT_OK) begin
         chain_head.push_back(e.result_block);
         if (chain_head.size() > 32) void'(chain_head.pop_front());
      end
   endtask

   // leaves the request channel idle until every outstanding result is back
   task automatic wait_drained();
      @(negedge clock);
      req_valid = 1'b0;
      while (pending_rsp.size() != 0) @(negedge clock);
      @(posedge clock);
   endtask

   task automatic write_csr(input logic [CSR_IDX_W-1:0] idx, input int unsigned value);
      logic [CSR_DATA_W-1:0] wdata;
      wdata = $urandom();
      if (idx == CSR_DATA_BASE) wdata[DB_W-1:0] = value;
      else if (idx == CSR_SCAN_LIMIT) wdata[SL_W-1:0] = value;
      @(negedge clock);
      csr_valid = 1'b1;
      csr_index = idx;
      csr_wdata = wdata;
      do @(posedge clock); while (!csr_ready);
      if (idx == CSR_DATA_BASE) cfg_base = wdata[DB_W-1:0];
      else if (idx == CSR_SCAN_LIMIT) cfg_limit = wdata[SL_W-1:0];
      @(negedge clock);
      csr_valid = 1'b0;
   endtask

   task automatic run_phase(input int base, input int limit, input int idle_pct,
                            input int stall_pct, input int items, input int hold,
                            input int pause_at);
      int n;
      req_idle_pct = idle_pct;
      rsp_stall_pct = stall_pct;
      write_csr(CSR_DATA_BASE, base);
      write_csr(CSR_SCAN_LIMIT, limit);
      settings_run++;
      @(posedge clock);
      hold_left = hold;
      for (n = 0; n < items; n++) begin
         if (n == pause_at) wait_drained();
         send_item(next_random_item(), 1'b0, '0);
      end
      wait_drained();
   endtask

   // result side: ready at the falling edge, long hold-offs counted down here
   initial begin
      rsp_ready = 1'b0;
      forever begin
         @(negedge clock);
         if (reset) rsp_ready = 1'b0;
         else if (hold_left > 0) begin
            rsp_ready = 1'b0;
            hold_left--;
         end else begin
            rsp_ready = ($urandom_range(0, 99) >= rsp_stall_pct);
         end
      end
   end

   always @(posedge clock) begin
      rsp_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (pending_rsp.size() == 0) begin
            $error("result transfer with nothing outstanding: %h", rsp_data);
            mismatches++;
         end else begin
            want = pending_rsp.pop_front();
            if (rsp_data.result_block !== want.result_block) begin
               $error("result_block: expected %0h, got %0h",
                      want.result_block, rsp_data.result_block);
               mismatches++;
            end
            if (rsp_data.bit_value !== want.bit_value) begin
               $error("bit_value: expected %0b, got %0b", want.bit_value, rsp_data.bit_value);
               mismatches++;
            end
            if (rsp_data.status !== want.status) begin
               $error("status: expected %0d, got %0d", want.status, rsp_data.status);
               mismatches++;
            end
         end
      end
   end

   // watchdog: cycles without any transfer on any channel
   initial begin
      stall_cycles = 0;
      while (stall_cycles < WATCHDOG_LIMIT) begin
         @(posedge clock);
         if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready) ||
             (csr_valid && csr_ready))
            stall_cycles = 0;
         else
            stall_cycles++;
      end
      $display("block_chain_allocator_top test failed");
      $finish;
   end

   initial begin
      int i;
      reset = 1'b1;
      req_valid = 1'b0;
      req_data = '0;
      csr_valid = 1'b0;
      csr_index = CSR_DATA_BASE;
      csr_wdata = '0;
      for (i = 0; i < MAP_BITS; i++) map_used[i] = 1'b0;
      for (i = 0; i < CHAIN_DEPTH; i++) begin
         link_word[i] = '0;
         link_set[i] = 1'b0;
      end
      for (i = 0; i < 8; i++) status_seen[i] = 0;
      cfg_base = 0;
      cfg_limit = SCAN_LIMIT_RST;

      //                mode         block      hops       link_value       typed result     bit   status
      dir_rows.push_back({MODE_ALLOC,  14'd0,     14'd0,     32'd0,           1'b1, 32'd0,     1'b0, STAT_OK});
      dir_rows.push_back({MODE_ALLOC,  14'd16383, 14'd16383, END_MARK,        1'b1, 32'd1,     1'b0, STAT_OK});
      dir_rows.push_back({MODE_APPEND, 14'd0,     14'd0,     32'd0,           1'b0, 32'd0,     1'b0, STAT_OK});
      dir_rows.push_back({MODE_APPEND, 14'd0,     14'd0,     32'd0,           1'b0, 32'd0,     1'b0, STAT_OK});
      dir_rows.push_back({MODE_SEEK,   14'd0,     14'd0,     32'd0,           1'b1, 32'd0,     1'b0, STAT_OK});
      dir_rows.push_back({MODE_SEEK,   14'd0,     14'd2,     32'd0,           1'b0, 32'd0,     1'b0, STAT_OK});
      // end mark reached long before the hop count
      dir_rows.push_back({MODE_SEEK,   14'd0,     14'd16383, 32'd0,           1'b0, 32'd0,     1'b0, STAT_OK});
      dir_rows.push_back({MODE_TRIM,   14'd0,     14'd0,     32'd0,           1'b0, 32'd0,     1'b0, STAT_OK});
      dir_rows.push_back({MODE_TRIM,   14'd1,     14'd0,     32'd0,           1'b1, 32'd1,     1'b0, STAT_SINGLE});
      dir_rows.push_back({MODE_READ,   14'd0,     14'd0,     32'd0,           1'b0, 32'd0,     1'b0, STAT_OK});
      dir_rows.push_back({MODE_WLINK,  14'd16383, 14'd0,     END_MARK,        1'b1, 32'd16383, 1'b0, STAT_OK});
      dir_rows.push_back({MODE_READ,   14'd16383, 14'd0,     32'd0,           1'b0, 32'd0,     1'b0, STAT_OK});
      dir_rows.push_back({MODE_SET,    14'd16383, 14'd0,     32'd0,           1'b1, 32'd16383, 1'b0, STAT_OK});
      dir_rows.push_back({MODE_READ,   14'd16383, 14'd0,     32'd0,           1'b0, 32'd0,     1'b0, STAT_OK});
      dir_rows.push_back({MODE_CLEAR,  14'd16383, 14'd0,     32'd0,           1'b1, 32'd16383, 1'b0, STAT_OK});
      // a link just past the table
      dir_rows.push_back({MODE_WLINK,  14'd5,     14'd0,     32'h0000_4000,   1'b0, 32'd0,     1'b0, STAT_OK});
      dir_rows.push_back({MODE_SEEK,   14'd5,     14'd1,     32'd0,           1'b0, 32'd0,     1'b0, STAT_OK});
      dir_rows.push_back({MODE_APPEND, 14'd5,     14'd0,     32'd0,           1'b0, 32'd0,     1'b0, STAT_OK});
      dir_rows.push_back({MODE_TRIM,   14'd5,     14'd0,     32'd0,           1'b0, 32'd0,     1'b0, STAT_OK});
      // self loop: full-length seek, then a tail walk that must give up
      dir_rows.push_back({MODE_WLINK,  14'd7,     14'd0,     32'd7,           1'b0, 32'd0,     1'b0, STAT_OK});
      dir_rows.push_back({MODE_SEEK,   14'd7,     14'd16383, 32'd0,           1'b0, 32'd0,     1'b0, STAT_OK});
      dir_rows.push_back({MODE_TRIM,   14'd7,     14'd0,     32'd0,           1'b0, 32'd0,     1'b0, STAT_OK});
      dir_rows.push_back({MODE_WLINK,  14'd8,     14'd0,     32'hFFFF_FFFE,   1'b0, 32'd0,     1'b0, STAT_OK});
      dir_rows.push_back({MODE_SEEK,   14'd8,     14'd3,     32'd0,           1'b0, 32'd0,     1'b0, STAT_OK});
      // the trimmed tail comes back first
      dir_rows.push_back({MODE_ALLOC,  14'd0,     14'd0,     32'd0,           1'b0, 32'd0,     1'b0, STAT_OK});

      repeat (11) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      foreach (dir_rows[i]) send_item(dir_rows[i].stim, dir_rows[i].typed, dir_rows[i].want);
      wait_drained();
      settings_run++;

      // base       limit                        idle stall items hold pause
      run_phase(0,     16384,                       0,   0,    130,  500,  65);
      run_phase(0,     8,                           84,  0,    70,   0,    -1);
      run_phase(3,     16384,                       0,   84,   120,  0,    -1);
      run_phase(16383, 16384,                       16,  16,   70,   0,    -1);
      run_phase(0,     0,                           0,   0,    40,   0,    -1);
      run_phase($urandom_range(0, 48), $urandom_range(64, 16384), 16, 16, 130, 0, -1);
      write_csr(CSR_SPARE, $urandom());
      run_phase(0,     16384,                       0,   0,    90,   0,    -1);

      repeat (TAIL_CYCLES) @(posedge clock);
      $display("Covered %0d requests under %0d register settings, with idle and stall phases.",
               requests_sent, settings_run);
      $display("Results: ok %0d, end of chain %0d, no space %0d, single block %0d, range %0d",
               status_seen[STAT_OK], status_seen[STAT_END], status_seen[STAT_NOSPACE],
               status_seen[STAT_SINGLE], status_seen[STAT_RANGE]);
      if (mismatches == 0)
         $display("block_chain_allocator_top test passed");
      else
         $display("block_chain_allocator_top test failed");
      $finish;
   end

endmodule
